@@ rtl/epst_pkg.sv @@
// Shared types and constants of the encoder position and speed tracker.
package epst_pkg;

  // Item function codes.
  localparam logic [1:0] FUNC_TICK      = 2'd0;
  localparam logic [1:0] FUNC_SET_DIR   = 2'd1;
  localparam logic [1:0] FUNC_RESET_POS = 2'd2;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_DEBOUNCE   = 2'd0;
  localparam logic [1:0] REG_TIMEOUT    = 2'd1;
  localparam logic [1:0] REG_WHEEL_UNIT = 2'd2;
  localparam logic [1:0] REG_LIFT_UNIT  = 2'd3;

  // Register reset values.
  localparam logic [15:0] DEBOUNCE_RESET   = 16'd0;
  localparam logic [19:0] TIMEOUT_RESET    = 20'd200000;
  localparam logic [23:0] WHEEL_UNIT_RESET = 24'd2896138;
  localparam logic [23:0] LIFT_UNIT_RESET  = 24'd32320;

  // Widths of the datapath.
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;
  localparam int TIME_W = 32;
  localparam int POS_W  = 48;
  localparam int UNIT_W = 24;
  localparam int SCALE_W = 20;
  localparam int PROD_W = UNIT_W + SCALE_W;
  localparam int CNT_W  = $clog2(PROD_W);

  // Microseconds per second, applied to units per tick before the division.
  localparam logic [SCALE_W-1:0] SPEED_SCALE = 20'd1000000;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIVIDE,
    ST_DONE
  } state_t;

  // Configuration register file contents.
  typedef struct packed {
    logic [15:0]       debounce_time;
    logic [19:0]       timeout_us;
    logic [UNIT_W-1:0] wheel_units_per_tick;
    logic [UNIT_W-1:0] lift_units_per_tick;
  } cfg_t;

  // One accepted command beat.
  typedef struct packed {
    logic [1:0]        func;
    logic [2:0]        pin_levels;
    logic [1:0]        motor;
    logic signed [1:0] direction;
  } cmd_t;

  // Sequencer strobes to the encoder lanes.
  typedef struct packed {
    logic apply;
    logic load;
    logic step;
  } lane_ctrl_t;

endpackage

@@ rtl/epst_cmd_if.sv @@
// Command channel: one tick, direction or position reset per beat.
interface epst_cmd_if;
  logic              valid;
  logic              ready;
  logic [1:0]        func;
  logic [2:0]        pin_levels;
  logic [1:0]        motor;
  logic signed [1:0] direction;

  modport source (output valid, func, pin_levels, motor, direction, input ready);
  modport sink (input valid, func, pin_levels, motor, direction, output ready);
endinterface

@@ rtl/epst_res_if.sv @@
// Result channel: positions and speeds of the three encoders per beat.
interface epst_res_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] position_left;
  logic signed [47:0] position_right;
  logic signed [47:0] position_lift;
  logic signed [47:0] speed_left;
  logic signed [47:0] speed_right;
  logic signed [47:0] speed_lift;

  modport source (output valid, position_left, position_right, position_lift,
                  speed_left, speed_right, speed_lift, input ready);
  modport sink (input valid, position_left, position_right, position_lift,
                speed_left, speed_right, speed_lift, output ready);
endinterface

@@ rtl/encoder_position_speed_tracker_unit.sv @@
// Top level of the encoder position and speed tracker.
//
// Usage: each command beat is a one-microsecond tick carrying the encoder pin
// levels, a set-direction command or a position reset. Every accepted beat
// yields exactly one result beat with the three positions and three speeds
// after that command has taken effect. Registers are written through the
// APB-style port (debounce at 0x0, timeout at 0x4, wheel units at 0x8, lift
// units at 0xC); the user must write them only while no command is in
// flight, since the block itself does not enforce it.
// Sequence: a command is applied at the accept edge, the speed dividends are
// loaded in the cycle after, and the 44-bit quotients are produced one bit
// per cycle by one bit-serial divider per encoder, all in parallel. The result
// beat is posted when the block goes idle, and the next command can be taken.
// The result register keeps the result while the receiver stalls; the next
// command may be accepted then, but its result waits for the register to free.
// Reset clears time, positions, periods and directions and restores the
// register defaults; no result is pending after reset.
module encoder_position_speed_tracker_unit
  import epst_pkg::*;
#(
  parameter int ENCODERS = 3
) (
  input  logic              clk,
  input  logic              rst,
  epst_cmd_if.sink          cmd,
  epst_res_if.source        status,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t              cfg;
  cmd_t              item;
  lane_ctrl_t        ctrl;
  state_t            state;
  state_t            state_next;
  logic [CNT_W-1:0]  div_count;
  logic [TIME_W-1:0] time_now;
  logic [TIME_W-1:0] tick_time;
  logic              accept;
  logic              out_load;
  logic              res_valid;
  logic [POS_W-1:0]  lane_pos [ENCODERS];
  logic [POS_W-1:0]  lane_spd [ENCODERS];
  logic [POS_W-1:0]  rep_pos  [3];
  logic [POS_W-1:0]  rep_spd  [3];

  epst_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign item.func       = cmd.func;
  assign item.pin_levels = cmd.pin_levels;
  assign item.motor      = cmd.motor;
  assign item.direction  = cmd.direction;

  assign accept    = cmd.valid && cmd.ready;
  assign tick_time = time_now + TIME_W'(1);

  // Microsecond counter advances on every tick command.
  always_ff @(posedge clk) begin
    if (rst) begin
      time_now <= '0;
    end else if (accept && (item.func == FUNC_TICK)) begin
      time_now <= tick_time;
    end
  end

  // Sequencer: next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (accept) state_next = ST_LOAD;
      ST_LOAD:   state_next = ST_DIVIDE;
      ST_DIVIDE: if (div_count == CNT_W'(PROD_W - 1)) state_next = ST_DONE;
      ST_DONE:   if (out_load) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Sequencer: strobes.
  always_comb begin
    cmd.ready  = (state == ST_IDLE);
    ctrl.apply = accept;
    ctrl.load  = (state == ST_LOAD);
    ctrl.step  = (state == ST_DIVIDE);
    out_load   = (state == ST_DONE) && (!res_valid || status.ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      div_count <= '0;
    end else begin
      state <= state_next;
      if (ctrl.step) begin
        div_count <= div_count + CNT_W'(1);
      end else begin
        div_count <= '0;
      end
    end
  end

  // One lane per encoder; only the first three have pins.
  for (genvar e = 0; e < ENCODERS; e++) begin : g_lane
    logic              level;
    logic              sel;
    logic [UNIT_W-1:0] units;

    if (e < 3) begin : g_pin
      assign level = item.pin_levels[e];
    end else begin : g_nopin
      assign level = 1'b0;
    end

    if (e < 2) begin : g_wheel
      assign units = cfg.wheel_units_per_tick;
    end else begin : g_lift
      assign units = cfg.lift_units_per_tick;
    end

    assign sel = ({30'd0, item.motor} == e);

    epst_lane u_lane (
      .clk            (clk),
      .rst            (rst),
      .ctrl           (ctrl),
      .item           (item),
      .level          (level),
      .sel            (sel),
      .units          (units),
      .debounce_time  (cfg.debounce_time),
      .timeout_us     (cfg.timeout_us),
      .tick_time      (tick_time),
      .time_now       (time_now),
      .position       (lane_pos[e]),
      .speed          (lane_spd[e])
    );
  end

  // Reported encoders; missing ones read as zero.
  for (genvar r = 0; r < 3; r++) begin : g_rep
    if (r < ENCODERS) begin : g_have
      assign rep_pos[r] = lane_pos[r];
      assign rep_spd[r] = lane_spd[r];
    end else begin : g_none
      assign rep_pos[r] = '0;
      assign rep_spd[r] = '0;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_load) begin
      res_valid <= 1'b1;
    end else if (status.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status.position_left  <= rep_pos[0];
      status.position_right <= rep_pos[1];
      status.position_lift  <= rep_pos[2];
      status.speed_left     <= rep_spd[0];
      status.speed_right    <= rep_spd[1];
      status.speed_lift     <= rep_spd[2];
    end
  end

  assign status.valid = res_valid;

endmodule

@@ rtl/epst_cfg_regs.sv @@
// APB-style configuration registers of the tracker.
module epst_cfg_regs
  import epst_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  // Register writes, one per access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_time        <= DEBOUNCE_RESET;
      cfg.timeout_us           <= TIMEOUT_RESET;
      cfg.wheel_units_per_tick <= WHEEL_UNIT_RESET;
      cfg.lift_units_per_tick  <= LIFT_UNIT_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_DEBOUNCE:   cfg.debounce_time        <= pwdata[15:0];
        REG_TIMEOUT:    cfg.timeout_us           <= pwdata[19:0];
        REG_WHEEL_UNIT: cfg.wheel_units_per_tick <= pwdata[UNIT_W-1:0];
        REG_LIFT_UNIT:  cfg.lift_units_per_tick  <= pwdata[UNIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back.
  always_comb begin
    case (reg_idx)
      REG_DEBOUNCE:   prdata = {16'd0, cfg.debounce_time};
      REG_TIMEOUT:    prdata = {12'd0, cfg.timeout_us};
      REG_WHEEL_UNIT: prdata = {8'd0, cfg.wheel_units_per_tick};
      REG_LIFT_UNIT:  prdata = {8'd0, cfg.lift_units_per_tick};
      default:        prdata = '0;
    endcase
  end

endmodule

@@ rtl/epst_sdiv.sv @@
// Bit-serial restoring divider: one quotient bit per step.
module epst_sdiv
  import epst_pkg::*;
(
  input  logic              clk,
  input  logic              start,
  input  logic              step,
  input  logic [PROD_W-1:0] dividend,
  input  logic [TIME_W-1:0] divisor,
  output logic [PROD_W-1:0] quotient
);

  // The dividend shifts out at the top while quotient bits shift in below.
  logic [PROD_W-1:0] dq;
  logic [TIME_W-1:0] rem;
  logic [TIME_W:0]   trial;
  logic              fits;

  assign trial    = {rem, dq[PROD_W-1]};
  assign fits     = trial >= {1'b0, divisor};
  assign quotient = dq;

  always_ff @(posedge clk) begin
    if (start) begin
      dq  <= dividend;
      rem <= '0;
    end else if (step) begin
      dq <= {dq[PROD_W-2:0], fits};
      if (fits) begin
        rem <= TIME_W'(trial - {1'b0, divisor});
      end else begin
        rem <= trial[TIME_W-1:0];
      end
    end
  end

endmodule

@@ rtl/epst_lane.sv @@
// One encoder: edge tracking, position accumulator and speed division.
module epst_lane
  import epst_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  lane_ctrl_t         ctrl,
  input  cmd_t               item,
  input  logic               level,
  input  logic               sel,
  input  logic [UNIT_W-1:0]  units,
  input  logic [15:0]        debounce_time,
  input  logic [19:0]        timeout_us,
  input  logic [TIME_W-1:0]  tick_time,
  input  logic [TIME_W-1:0]  time_now,
  output logic [POS_W-1:0]   position,
  output logic [POS_W-1:0]   speed
);

  logic              expect_high;
  logic [TIME_W-1:0] last_rise_time;
  logic [TIME_W-1:0] edge_period;
  logic [POS_W-1:0]  position_acc;
  logic              reverse_dir;
  logic              speed_zero;

  logic [TIME_W-1:0] since;
  logic [TIME_W-1:0] late;
  logic              counts;
  logic [PROD_W-1:0] product;
  logic [PROD_W-1:0] quotient;
  logic [POS_W-1:0]  magnitude;

  assign since   = tick_time - last_rise_time;
  assign counts  = (level == expect_high) && (since > {16'd0, debounce_time});
  assign late    = time_now - last_rise_time;
  assign product = PROD_W'(units) * PROD_W'(SPEED_SCALE);

  // State update when a command beat is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      expect_high    <= 1'b1;
      last_rise_time <= '0;
      edge_period    <= '0;
      position_acc   <= '0;
      reverse_dir    <= 1'b0;
    end else if (ctrl.apply) begin
      case (item.func)
        FUNC_TICK: begin
          if (counts) begin
            if (expect_high) begin
              edge_period    <= since;
              last_rise_time <= tick_time;
              if (reverse_dir) begin
                position_acc <= position_acc - POS_W'(units);
              end else begin
                position_acc <= position_acc + POS_W'(units);
              end
            end
            expect_high <= !expect_high;
          end
        end
        FUNC_SET_DIR: begin
          if (sel) begin
            if (item.direction == 2'sd1) begin
              reverse_dir <= 1'b0;
            end else if (item.direction[1]) begin
              reverse_dir <= 1'b1;
            end
          end
        end
        FUNC_RESET_POS: begin
          if (sel) begin
            position_acc <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // Stale or missing period forces zero speed; decided before the division.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      speed_zero <= (edge_period > {12'd0, timeout_us}) ||
                    (late > {12'd0, timeout_us}) ||
                    (edge_period == '0);
    end
  end

  epst_sdiv u_sdiv (
    .clk      (clk),
    .start    (ctrl.load),
    .step     (ctrl.step),
    .dividend (product),
    .divisor  (edge_period),
    .quotient (quotient)
  );

  // Signed speed from the unsigned quotient.
  assign magnitude = POS_W'(quotient);
  assign position  = position_acc;

  always_comb begin
    if (speed_zero) begin
      speed = '0;
    end else if (reverse_dir) begin
      speed = -magnitude;
    end else begin
      speed = magnitude;
    end
  end

endmodule

@@ rtl/epst_checker.sv @@
// Port-level checks of the tracker, bound to the top level.
module epst_checker (
  input logic        clk,
  input logic        rst,
  input logic        cmd_valid,
  input logic        cmd_ready,
  input logic        status_valid,
  input logic        status_ready,
  input logic [47:0] position_left,
  input logic [47:0] speed_left
);

  // A result beat stays offered until it is taken.
  assert property (@(posedge clk) disable iff (rst)
    status_valid && !status_ready |=> status_valid)
    else $error("result beat dropped before it was taken");

  // A stalled result keeps its payload.
  assert property (@(posedge clk) disable iff (rst)
    status_valid && !status_ready |=> $stable(position_left) && $stable(speed_left))
    else $error("stalled result payload changed");

  // One command at a time: the block is busy right after an accept.
  assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("command accepted while the previous one is in flight");

  // A new result is posted exactly when the block goes idle again.
  assert property (@(posedge clk) disable iff (rst)
    $rose(status_valid) |-> cmd_ready)
    else $error("result posted while the block is still busy");

endmodule

bind encoder_position_speed_tracker_unit epst_checker u_epst_checker (
  .clk           (clk),
  .rst           (rst),
  .cmd_valid     (cmd.valid),
  .cmd_ready     (cmd.ready),
  .status_valid  (status.valid),
  .status_ready  (status.ready),
  .position_left (status.position_left),
  .speed_left    (status.speed_left)
);
